### hw/rtl/rgb565_color_adjust_defines.svh
// assertion macros shared by the color adjust rtl
`ifndef RGB565_COLOR_ADJUST_DEFINES_SVH
`define RGB565_COLOR_ADJUST_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rca_pkg.sv
// types, constants and expansion tables for the rgb565 color adjust block
package rca_pkg;

   typedef enum logic [7:0] {
      CSR_SWAP_RB = 8'd0,
      CSR_INVERT  = 8'd1,
      CSR_GAIN_R  = 8'd2,
      CSR_GAIN_G  = 8'd3,
      CSR_GAIN_B  = 8'd4
   } csr_index_type;

   localparam logic [7:0] GainUnity = 8'd100;
   localparam logic [7:0] GainLimit = 8'd200;
   localparam logic [7:0] ChMax     = 8'd255;

   localparam int ChMaxInt   = 255;
   localparam int Field5Max  = 31;
   localparam int Field6Max  = 63;

   // divide by 100 as multiply by ceil(2^19 / 100) and shift, exact below 43691;
   // larger products are above 25599 and saturate either way
   localparam int            RecipShift = 19;
   localparam logic [12:0]   RecipMul   = 13'd5243;
   localparam int            ProdWidth  = 16;
   localparam int            QuotWidth  = ProdWidth + 13;

   typedef logic [7:0] exp5_type [32];
   typedef logic [7:0] exp6_type [64];

   function automatic exp5_type build_exp5();
      exp5_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * ChMaxInt) / Field5Max);
      end
      return t;
   endfunction

   function automatic exp6_type build_exp6();
      exp6_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * ChMaxInt) / Field6Max);
      end
      return t;
   endfunction

   localparam exp5_type Exp5Tbl = build_exp5();
   localparam exp6_type Exp6Tbl = build_exp6();

   typedef struct packed {
      logic       swap_rb;
      logic       invert;
      logic [7:0] gain_r;
      logic [7:0] gain_g;
      logic [7:0] gain_b;
   } cfg_type;

   // after expansion and swap
   typedef struct packed {
      logic        valid;
      logic        neutral;
      logic [15:0] pixel;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } exp_beat_type;

   // after channel times gain
   typedef struct packed {
      logic                 valid;
      logic                 neutral;
      logic [15:0]          pixel;
      logic [ProdWidth-1:0] red;
      logic [ProdWidth-1:0] green;
      logic [ProdWidth-1:0] blue;
   } prod_beat_type;

   // after multiply by the reciprocal of 100
   typedef struct packed {
      logic                 valid;
      logic                 neutral;
      logic [15:0]          pixel;
      logic [QuotWidth-1:0] red;
      logic [QuotWidth-1:0] green;
      logic [QuotWidth-1:0] blue;
   } quot_beat_type;

endpackage

### hw/rtl/rgb565_color_adjust.sv
// rgb565 color adjust: expansion, red/blue swap, percent gain, invert, repack
//
// Takes one RGB565 pixel per clock whenever start is high (busy is always low)
// and returns the adjusted pixel on rsp_pixel_out, marked by a one-cycle
// rsp_valid strobe; the receiver cannot stall. The register stages are the
// channel expansion and swap, the channel times gain multiply, the
// divide-by-100 reciprocal multiply, and the saturate,
// invert and repack output register. Registers are written through the csr_
// port (index 0 swap, 1 invert, 2..4 red/green/blue gain) and may only be
// written when no pixel has been started in the last four cycles.
module rgb565_color_adjust (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_pixel_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_pixel_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import rca_pkg::*;
   `include "rgb565_color_adjust_defines.svh"

   cfg_type       cfg;
   exp_beat_type  exp_beat;
   quot_beat_type quot_beat;
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   rca_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rca_expand u_expand (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_pixel (req_pixel_in),
      .cfg      (cfg),
      .out_beat (exp_beat)
   );

   rca_gain u_gain (
      .clock    (clock),
      .reset    (reset),
      .in_beat  (exp_beat),
      .cfg      (cfg),
      .out_beat (quot_beat)
   );

   rca_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (quot_beat),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out)
   );

   `RCA_ASSERT_SAME(a_rsp_has_request, clock, reset, rsp_valid,
      $past(accept, 4), "result beat without a request four cycles earlier")

endmodule

### hw/rtl/rca_csr.sv
// configuration registers with gain clamping
module rca_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output rca_pkg::cfg_type cfg
);
   import rca_pkg::*;
   `include "rgb565_color_adjust_defines.svh"

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [7:0] gain_wr;
   logic       wr_en;

   assign wr_en     = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      gain_wr = csr_wdata;
      if (gain_wr > GainLimit) begin
         gain_wr = GainLimit;
      end
      if (gain_wr == 8'd0) begin
         gain_wr = GainUnity;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_SWAP_RB: cfg_in.swap_rb = csr_wdata[0];
            CSR_INVERT:  cfg_in.invert  = csr_wdata[0];
            CSR_GAIN_R:  cfg_in.gain_r  = gain_wr;
            CSR_GAIN_G:  cfg_in.gain_g  = gain_wr;
            CSR_GAIN_B:  cfg_in.gain_b  = gain_wr;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_rb <= 1'b0;
         cfg_ff.invert  <= 1'b0;
         cfg_ff.gain_r  <= GainUnity;
         cfg_ff.gain_g  <= GainUnity;
         cfg_ff.gain_b  <= GainUnity;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   `RCA_ASSERT_SAME(a_gain_r_range, clock, reset, 1'b1,
      cfg_ff.gain_r >= 8'd1 && cfg_ff.gain_r <= GainLimit, "red gain out of range")
   `RCA_ASSERT_NEXT(a_bad_index_no_effect, clock, reset,
      wr_en && csr_index > CSR_GAIN_B, $stable(cfg_ff), "write past last register took effect")

endmodule

### hw/rtl/rca_expand.sv
// stage one: expand 5:6:5 to 8 bits per channel, optional red/blue swap
module rca_expand (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [15:0]           in_pixel,
   input  rca_pkg::cfg_type      cfg,
   output rca_pkg::exp_beat_type out_beat
);
   import rca_pkg::*;

   exp_beat_type beat_ff;
   exp_beat_type beat_in;
   logic [7:0]   red_x;
   logic [7:0]   green_x;
   logic [7:0]   blue_x;

   always_comb begin
      red_x   = Exp5Tbl[in_pixel[15:11]];
      green_x = Exp6Tbl[in_pixel[10:5]];
      blue_x  = Exp5Tbl[in_pixel[4:0]];
      beat_in.valid   = in_valid;
      beat_in.neutral = !cfg.swap_rb && !cfg.invert &&
                        cfg.gain_r == GainUnity && cfg.gain_g == GainUnity &&
                        cfg.gain_b == GainUnity;
      beat_in.pixel   = in_pixel;
      beat_in.green   = green_x;
      beat_in.red     = cfg.swap_rb ? blue_x : red_x;
      beat_in.blue    = cfg.swap_rb ? red_x : blue_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   assign out_beat = beat_ff;

endmodule

### hw/rtl/rca_gain.sv
// stages two and three: channel times gain, then times reciprocal of 100
module rca_gain (
   input  logic                   clock,
   input  logic                   reset,
   input  rca_pkg::exp_beat_type  in_beat,
   input  rca_pkg::cfg_type       cfg,
   output rca_pkg::quot_beat_type out_beat
);
   import rca_pkg::*;
   `include "rgb565_color_adjust_defines.svh"

   prod_beat_type prod_ff;
   prod_beat_type prod_in;
   quot_beat_type quot_ff;
   quot_beat_type quot_in;

   always_comb begin
      prod_in.valid   = in_beat.valid;
      prod_in.neutral = in_beat.neutral;
      prod_in.pixel   = in_beat.pixel;
      prod_in.red     = ProdWidth'(in_beat.red)   * ProdWidth'(cfg.gain_r);
      prod_in.green   = ProdWidth'(in_beat.green) * ProdWidth'(cfg.gain_g);
      prod_in.blue    = ProdWidth'(in_beat.blue)  * ProdWidth'(cfg.gain_b);
   end

   always_comb begin
      quot_in.valid   = prod_ff.valid;
      quot_in.neutral = prod_ff.neutral;
      quot_in.pixel   = prod_ff.pixel;
      quot_in.red     = QuotWidth'(prod_ff.red)   * QuotWidth'(RecipMul);
      quot_in.green   = QuotWidth'(prod_ff.green) * QuotWidth'(RecipMul);
      quot_in.blue    = QuotWidth'(prod_ff.blue)  * QuotWidth'(RecipMul);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff <= '0;
         quot_ff <= '0;
      end else begin
         prod_ff <= prod_in;
         quot_ff <= quot_in;
      end
   end

   assign out_beat = quot_ff;

   `RCA_ASSERT_NEXT(a_expand_to_prod, clock, reset, in_beat.valid, prod_ff.valid,
      "beat lost between expand and product stage")
   `RCA_ASSERT_NEXT(a_prod_to_quot, clock, reset, prod_ff.valid, quot_ff.valid,
      "beat lost between product and quotient stage")

endmodule

### hw/rtl/rca_pack.sv
// stage four: shift out quotient, saturate, invert, repack to 5:6:5, or pass the original pixel when neutral
module rca_pack (
   input  logic                   clock,
   input  logic                   reset,
   input  rca_pkg::quot_beat_type in_beat,
   input  rca_pkg::cfg_type       cfg,
   output logic                   out_valid,
   output logic [15:0]            out_pixel
);
   import rca_pkg::*;

   localparam int QuotHi = QuotWidth - 1;

   logic        valid_ff;
   logic        valid_in;
   logic [15:0] pixel_ff;
   logic [15:0] pixel_in;
   logic [QuotHi-RecipShift:0] red_q;
   logic [QuotHi-RecipShift:0] green_q;
   logic [QuotHi-RecipShift:0] blue_q;
   logic [7:0]  red_s;
   logic [7:0]  green_s;
   logic [7:0]  blue_s;

   always_comb begin
      red_q   = in_beat.red[QuotHi:RecipShift];
      green_q = in_beat.green[QuotHi:RecipShift];
      blue_q  = in_beat.blue[QuotHi:RecipShift];
      red_s   = (red_q   > (QuotWidth-RecipShift)'(ChMax)) ? ChMax : red_q[7:0];
      green_s = (green_q > (QuotWidth-RecipShift)'(ChMax)) ? ChMax : green_q[7:0];
      blue_s  = (blue_q  > (QuotWidth-RecipShift)'(ChMax)) ? ChMax : blue_q[7:0];
      // 255 - v on eight bits is the bitwise complement
      if (cfg.invert) begin
         red_s   = ~red_s;
         green_s = ~green_s;
         blue_s  = ~blue_s;
      end
      valid_in = in_beat.valid;
      pixel_in = in_beat.neutral ? in_beat.pixel : {red_s[7:3], green_s[7:2], blue_s[7:3]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

### tb/rgb565_color_adjust_tb.sv
// self-checking testbench for the rgb565 color adjust block
`timescale 1ns / 100ps

module rgb565_color_adjust_tb;
   import rca_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_pixel_in = 16'h0000;
   logic        rsp_valid;
   logic [15:0] rsp_pixel_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'h00;
   logic [7:0]  csr_wdata = 8'h00;

   // shadow copy of the block's settings
   logic       cfg_swap = 1'b0;
   logic       cfg_invert = 1'b0;
   logic [7:0] cfg_gain_r = GainUnity;
   logic [7:0] cfg_gain_g = GainUnity;
   logic [7:0] cfg_gain_b = GainUnity;

   logic [15:0] pixel_q[$];
   logic [15:0] adjusted_px_q[$];
   int          send_idle_pct = 0;
   int          error_count = 0;

   rgb565_color_adjust uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] gain_after_write(input logic [7:0] data);
      logic [7:0] g;
      g = data;
      if (g > GainLimit) g = GainLimit;
      if (g == 8'd0) g = GainUnity;
      return g;
   endfunction

   function automatic int scale_chan(input int v, input logic [7:0] gain);
      int p;
      p = (v * int'(gain)) / int'(GainUnity);
      return (p > ChMaxInt) ? ChMaxInt : p;
   endfunction

   function automatic logic [15:0] adjust_pixel(input logic [15:0] px);
      int         r, g, b, t;
      logic [7:0] r8, g8, b8;
      if (!cfg_swap && !cfg_invert && cfg_gain_r == GainUnity &&
          cfg_gain_g == GainUnity && cfg_gain_b == GainUnity) begin
         return px;
      end
      r = (int'(px[15:11]) * ChMaxInt) / Field5Max;
      g = (int'(px[10:5]) * ChMaxInt) / Field6Max;
      b = (int'(px[4:0]) * ChMaxInt) / Field5Max;
      if (cfg_swap) begin
         t = r;
         r = b;
         b = t;
      end
      r = scale_chan(r, cfg_gain_r);
      g = scale_chan(g, cfg_gain_g);
      b = scale_chan(b, cfg_gain_b);
      if (cfg_invert) begin
         r = ChMaxInt - r;
         g = ChMaxInt - g;
         b = ChMaxInt - b;
      end
      r8 = 8'(r);
      g8 = 8'(g);
      b8 = 8'(b);
      return {r8[7:3], g8[7:2], b8[7:3]};
   endfunction

   // pixel driver: one beat per accepting edge, random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) adjusted_px_q.push_back(adjust_pixel(req_pixel_in));
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            start        <= 1'b1;
            req_pixel_in <= pixel_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (adjusted_px_q.size() == 0) begin
            $display("%0t: unexpected pixel_out %h", $time, rsp_pixel_out);
            error_count++;
         end else begin
            logic [15:0] want;
            want = adjusted_px_q.pop_front();
            if (rsp_pixel_out !== want) begin
               $display("%0t: pixel_out expected %h actual %h", $time, want, rsp_pixel_out);
               error_count++;
            end
         end
      end
   end

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SWAP_RB: cfg_swap = data[0];
         CSR_INVERT:  cfg_invert = data[0];
         CSR_GAIN_R:  cfg_gain_r = gain_after_write(data);
         CSR_GAIN_G:  cfg_gain_g = gain_after_write(data);
         CSR_GAIN_B:  cfg_gain_b = gain_after_write(data);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // wait until every queued pixel has come back, then let the pipe settle
   task automatic drain();
      while (pixel_q.size() != 0 || start || adjusted_px_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_gain();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd1;
         2: return GainUnity;
         3: return GainLimit;
         4: return 8'($urandom_range(255, 201));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   initial begin
      int idle_choice[3];
      idle_choice = '{0, 78, 9};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // neutral settings pass the pixel through untouched
      pixel_q = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'h001f, 16'h8410};
      drain();

      // swap, spare bits set in the write data
      write_csr(CSR_SWAP_RB, 8'hff);
      pixel_q = '{16'hf800, 16'h001f, 16'h1234};
      drain();

      write_csr(CSR_SWAP_RB, 8'hfe);
      write_csr(CSR_INVERT, 8'h01);
      pixel_q = '{16'h0000, 16'hffff};
      drain();

      // gain clamp above the limit, minimum gain, zero write back to unity
      write_csr(CSR_INVERT, 8'h00);
      write_csr(CSR_GAIN_R, 8'hff);
      write_csr(CSR_GAIN_G, 8'h01);
      write_csr(CSR_GAIN_B, 8'h00);
      pixel_q = '{16'hffff, 16'h8410, 16'h0841};
      drain();

      // writes past the register list change nothing
      write_csr(CSR_GAIN_R, 8'd100);
      write_csr(CSR_GAIN_G, 8'd100);
      write_csr(8'd5, 8'h00);
      write_csr(8'hff, 8'hff);
      pixel_q = '{16'h1234};
      drain();

      // just off neutral forces the 5:6:5 round trip
      write_csr(CSR_GAIN_R, 8'd101);
      pixel_q = '{16'h0001, 16'h07ff};
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         send_idle_pct = idle_choice[phase % 3];
         if ($urandom_range(4) == 0) begin
            write_csr(CSR_SWAP_RB, {7'($urandom), 1'b0});
            write_csr(CSR_INVERT, {7'($urandom), 1'b0});
            write_csr(CSR_GAIN_R, GainUnity);
            write_csr(CSR_GAIN_G, GainUnity);
            write_csr(CSR_GAIN_B, GainUnity);
         end else begin
            write_csr(CSR_SWAP_RB, 8'($urandom));
            write_csr(CSR_INVERT, 8'($urandom));
            write_csr(CSR_GAIN_R, pick_gain());
            write_csr(CSR_GAIN_G, pick_gain());
            write_csr(CSR_GAIN_B, pick_gain());
         end
         if ($urandom_range(2) == 0) write_csr(8'($urandom_range(255, 5)), 8'($urandom));
         for (int n = 0; n < 125; n++) pixel_q.push_back(16'($urandom));
         drain();
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
